@@ hw/rtl/mcps_pkg.sv @@
// Shared types and constants of the multi-channel pulse scheduler.
package mcps_pkg;

	localparam int SLOT_IDX_W = 6;
	localparam int CH_W       = 4;
	localparam int MASK_W     = 16;
	localparam int TIME_W     = 32;
	localparam int DUR_W      = 31;
	localparam int CHK_W      = 7;

	typedef logic [1:0] req_t;

	localparam req_t REQ_SCHEDULE = 2'd0;
	localparam req_t REQ_CANCEL   = 2'd1;
	localparam req_t REQ_TICK     = 2'd2;

	typedef struct packed {
		req_t            req;
		logic            ch_ok;
		logic [CH_W-1:0] channel;
		logic [TIME_W-1:0] off_time;
	} cmd_t;

	typedef struct packed {
		logic                  live;
		logic                  hit;
		logic                  free_found;
		logic [SLOT_IDX_W-1:0] free_idx;
		logic [MASK_W-1:0]     expired;
	} tok_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] idx;
	} fill_t;

endpackage

@@ hw/rtl/mcps_req_if.sv @@
// Request channel of the pulse scheduler.
interface mcps_req_if import mcps_pkg::*; ();
	logic              valid;
	logic              ready;
	req_t              req_type;
	logic [CH_W-1:0]   channel;
	logic [DUR_W-1:0]  duration_ms;

	modport source(output valid, req_type, channel, duration_ms, input ready);
	modport sink(input valid, req_type, channel, duration_ms, output ready);
endinterface

@@ hw/rtl/mcps_res_if.sv @@
// Result channel of the pulse scheduler.
interface mcps_res_if import mcps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [MASK_W-1:0] output_levels;
	logic [MASK_W-1:0] expired_mask;

	modport source(output valid, accepted, output_levels, expired_mask, input ready);
	modport sink(input valid, accepted, output_levels, expired_mask, output ready);
endinterface

@@ hw/rtl/multi_channel_pulse_scheduler_unit.sv @@
// Top level of the multi-channel pulse scheduler: request control, level register, slot chain.
//
//   port  | role   | payload
//   ------+--------+--------------------------------------------
//   req   | sink   | req_type, channel, duration_ms
//   res   | source | accepted, output_levels, expired_mask
//
// Each transfer on req sends a token down the chain of SLOTS slot cells, one cell per cycle,
// so req is not ready again until the token has left the last cell and its result is registered.
// A free slot is filled as the token leaves the chain.
// Reset clears the clock, all slot active bits and all output levels at once.
// A stalled res keeps one result in the output register while the next request walks;
// a second finished result then waits in ST_HOLD with req not ready.
module multi_channel_pulse_scheduler_unit import mcps_pkg::*; #(
	parameter int SLOTS    = 10,
	parameter int CHANNELS = 16
) (
	input logic       clk,
	input logic       arst_n,
	mcps_req_if.sink  req,
	mcps_res_if.source res
);

	localparam int LVL_W = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_HOLD} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	tok_t              head_q;
	tok_t              tok [SLOTS+1];
	tok_t              last;
	fill_t             fill;
	logic [TIME_W-1:0] now_q;
	logic [LVL_W-1:0]  level_q;
	logic [LVL_W-1:0]  level_d;
	logic [MASK_W-1:0] ch_oh;
	logic [SLOTS:0]    live_vec;
	logic              in_xfer;
	logic              out_free;
	logic              out_load;
	logic              fin_acc;
	logic              hold_acc_q;
	logic [MASK_W-1:0] hold_exp_q;
	logic              out_valid_q;
	logic              out_acc_q;
	logic [MASK_W-1:0] out_lvl_q;
	logic [MASK_W-1:0] out_exp_q;

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign out_load  = out_free && ((state_q == ST_HOLD) ||
		((state_q == ST_WALK) && last.live));

	assign tok[0] = head_q;
	assign last   = tok[SLOTS];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		mcps_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd_q),
			.now     (now_q),
			.fill    (fill),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	for (genvar i = 0; i <= SLOTS; i++) begin : g_live
		assign live_vec[i] = tok[i].live;
	end

	always_comb begin
		ch_oh   = MASK_W'(1) << cmd_q.channel;
		fin_acc = !((cmd_q.req == REQ_SCHEDULE) &&
			(!cmd_q.ch_ok || (!last.hit && !last.free_found)));
		fill.en  = last.live && (cmd_q.req == REQ_SCHEDULE) && cmd_q.ch_ok &&
			!last.hit && last.free_found;
		fill.idx = last.free_idx;
		level_d  = level_q;
		case (cmd_q.req)
			REQ_SCHEDULE: begin
				if (fin_acc)
					level_d = level_q | ch_oh[LVL_W-1:0];
			end
			REQ_CANCEL: begin
				if (last.hit)
					level_d = level_q & ~ch_oh[LVL_W-1:0];
			end
			REQ_TICK: level_d = level_q & ~last.expired[LVL_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q.req      <= req.req_type;
			cmd_q.channel  <= req.channel;
			cmd_q.ch_ok    <= (CHK_W'(req.channel) < CHK_W'(CHANNELS));
			cmd_q.off_time <= now_q + TIME_W'(req.duration_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			now_q       <= '0;
			level_q     <= '0;
			hold_acc_q  <= 1'b0;
			hold_exp_q  <= '0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_lvl_q   <= '0;
			out_exp_q   <= '0;
		end else begin
			head_q.live <= in_xfer;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (req.req_type == REQ_TICK)
							now_q <= now_q + TIME_W'(1);
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (last.live) begin
						level_q <= level_d;
						if (out_free) begin
							out_acc_q   <= fin_acc;
							out_lvl_q   <= MASK_W'(level_d);
							out_exp_q   <= last.expired;
							state_q     <= ST_IDLE;
						end else begin
							hold_acc_q <= fin_acc;
							hold_exp_q <= last.expired;
							state_q    <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_acc_q   <= hold_acc_q;
						out_lvl_q   <= MASK_W'(level_q);
						out_exp_q   <= hold_exp_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.accepted      = out_acc_q;
	assign res.output_levels = out_lvl_q;
	assign res.expired_mask  = out_exp_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one token in the slot chain");

	a_token_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		last.live |-> (state_q == ST_WALK))
		else $error("token left the chain outside a walk");

	a_expired_low: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ((res.output_levels & res.expired_mask) == '0))
		else $error("expired channel still reported high");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> out_valid_q)
		else $error("result held while output register empty");

endmodule

@@ hw/rtl/mcps_cell.sv @@
// One pulse slot: holds its channel and off time and acts on the token passing through.
module mcps_cell import mcps_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [TIME_W-1:0] now,
	input  fill_t             fill,
	input  tok_t              tok_in,
	output tok_t              tok_out
);

	logic              active_q;
	logic [CH_W-1:0]   chan_q;
	logic [TIME_W-1:0] off_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic              match;
	logic              expire;
	logic              fill_here;
	logic [TIME_W-1:0] age;
	logic [MASK_W-1:0] chan_oh;

	always_comb begin
		match     = active_q && (chan_q == cmd.channel) && cmd.ch_ok;
		age       = now - off_q;
		expire    = active_q && !age[TIME_W-1];
		fill_here = fill.en && (fill.idx == SLOT_IDX_W'(IDX));
		chan_oh   = MASK_W'(1) << chan_q;
		tok_d     = tok_in;
		if (tok_in.live) begin
			case (cmd.req)
				REQ_SCHEDULE: begin
					if (match)
						tok_d.hit = 1'b1;
					if (!active_q && !tok_in.free_found) begin
						tok_d.free_found = 1'b1;
						tok_d.free_idx   = SLOT_IDX_W'(IDX);
					end
				end
				REQ_CANCEL: begin
					if (match)
						tok_d.hit = 1'b1;
				end
				REQ_TICK: begin
					if (expire)
						tok_d.expired = tok_in.expired | chan_oh;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_d;
			if (fill_here)
				active_q <= 1'b1;
			else if (tok_in.live && (((cmd.req == REQ_CANCEL) && match) ||
					((cmd.req == REQ_TICK) && expire)))
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_here) begin
			chan_q <= cmd.channel;
			off_q  <= cmd.off_time;
		end else if (tok_in.live && (cmd.req == REQ_SCHEDULE) && match) begin
			off_q <= cmd.off_time;
		end
	end

	assign tok_out = tok_q;

endmodule
